[sv/assert_macros.svh]
// Assertion macros used by the checker module of the loopback byte FIFO.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define PLF_ASSERT(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// The antecedent at one edge implies the consequent at the next edge.
`define PLF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/plf_pkg.sv]
// Package of the loopback byte FIFO: ring geometry, command and status codes,
// pointer helpers and the controller command type. No dependencies.
package plf_pkg;

   localparam int RING_DEPTH = 64;
   localparam int PTR_W      = $clog2(RING_DEPTH);
   localparam int CNT_W      = PTR_W + 1;

   localparam int CMD_W    = 2;
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 8;
   localparam int PERIOD_W = 24;
   localparam int SLACK_W  = 32;

   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_TX_FULL  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_RX_EMPTY = 3'd2;
   localparam logic [STATUS_W-1:0] ST_RX_FULL  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_WAIT     = 3'd4;
   localparam logic [STATUS_W-1:0] ST_TX_EMPTY = 3'd5;

   localparam logic [SLACK_W-1:0] SLACK_MAX = '1;

   typedef logic [PTR_W-1:0] ptr_type;

   typedef struct packed {
      logic capture;
      logic execute;
      logic finish;
   } plf_cmd_type;

   function automatic ptr_type ptr_next(input ptr_type p);
      return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : ptr_type'(p + 1'b1);
   endfunction

   function automatic logic [COUNT_W-1:0] ring_fill(input ptr_type wp, input ptr_type rp);
      logic [CNT_W-1:0] diff;
      if (wp >= rp) begin
         diff = {1'b0, wp} - {1'b0, rp};
      end else begin
         diff = {1'b0, wp} + CNT_W'(RING_DEPTH) - {1'b0, rp};
      end
      return COUNT_W'(diff);
   endfunction

endpackage

[sv/plf_if.sv]
// Channel interfaces of the loopback byte FIFO: command beats in, result beats out.
// Depends on plf_pkg for field widths.
interface plf_req_if;
   logic                         valid;
   logic                         ready;
   logic [plf_pkg::CMD_W-1:0]    command;
   logic [plf_pkg::BYTE_W-1:0]   data_byte;

   modport source (output valid, output command, output data_byte, input ready);
   modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface plf_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [plf_pkg::BYTE_W-1:0]    read_byte;
   logic [plf_pkg::STATUS_W-1:0]  status;
   logic [plf_pkg::COUNT_W-1:0]   rx_count;

   modport source (output valid, output read_byte, output status, output rx_count,
                   input ready);
   modport sink   (input valid, input read_byte, input status, input rx_count,
                   output ready);
endinterface

[sv/paced_loopback_byte_fifo_top.sv]
// Top level of the paced loopback byte FIFO: a transmit ring and a receive ring
// joined by a microsecond-paced transfer. Depends on plf_pkg, plf_if, plf_ctrl
// and plf_datapath.
//
// Usage: each beat on the req_bus channel carries a command (write a byte to the
// transmit ring, read the receive ring, or a one-microsecond tick) and a data byte.
// Every command beat yields exactly one beat on rsp_bus with the byte read, a
// status code and the receive ring fill after the command.
// The frame period in microseconds is written through csr_wr_en and csr_wr_data
// while the block is idle.
// The result beat becomes valid after the command beat is taken and has passed the
// execute and finish steps. The controller takes one command beat at a time and
// takes no new command before the last result beat is accepted.
// Each ring holds at most 63 bytes.
// A stalled result holds rsp_bus steady and no new command is taken until it goes.
// Reset empties both rings, clears the slack counter and the frame period.
module paced_loopback_byte_fifo_top (
   input  logic                          clock,
   input  logic                          reset,
   plf_req_if.sink                       req_bus,
   plf_rsp_if.source                     rsp_bus,
   input  logic                          csr_wr_en,
   input  logic [plf_pkg::PERIOD_W-1:0]  csr_wr_data
);

   plf_pkg::plf_cmd_type cmd;
   logic                 req_ready;
   logic                 rsp_valid;

   plf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   plf_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_command   (req_bus.command),
      .req_data_byte (req_bus.data_byte),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .rsp_read_byte (rsp_bus.read_byte),
      .rsp_status    (rsp_bus.status),
      .rsp_rx_count  (rsp_bus.rx_count)
   );

   assign req_bus.ready = req_ready;
   assign rsp_bus.valid = rsp_valid;

endmodule

[sv/plf_datapath.sv]
// Datapath of the loopback byte FIFO: both rings with their pointers, the slack
// counter, the period register and the result registers. Depends on plf_pkg.
module plf_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  plf_pkg::plf_cmd_type          cmd,
   input  logic [plf_pkg::CMD_W-1:0]     req_command,
   input  logic [plf_pkg::BYTE_W-1:0]    req_data_byte,
   input  logic                          csr_wr_en,
   input  logic [plf_pkg::PERIOD_W-1:0]  csr_wr_data,
   output logic [plf_pkg::BYTE_W-1:0]    rsp_read_byte,
   output logic [plf_pkg::STATUS_W-1:0]  rsp_status,
   output logic [plf_pkg::COUNT_W-1:0]   rsp_rx_count
);

   logic [plf_pkg::BYTE_W-1:0] tx_mem [plf_pkg::RING_DEPTH];
   logic [plf_pkg::BYTE_W-1:0] rx_mem [plf_pkg::RING_DEPTH];

   plf_pkg::ptr_type tx_wp_ff, tx_wp_in, tx_rp_ff, tx_rp_in;
   plf_pkg::ptr_type rx_wp_ff, rx_wp_in, rx_rp_ff, rx_rp_in;
   plf_pkg::ptr_type rx_waddr_ff;
   logic [plf_pkg::SLACK_W-1:0]  slack_ff, slack_in, slack_inc;
   logic [plf_pkg::PERIOD_W-1:0] period_ff;

   logic [plf_pkg::CMD_W-1:0]    cmd_ff;
   logic [plf_pkg::BYTE_W-1:0]   data_ff;
   logic [plf_pkg::BYTE_W-1:0]   tx_rdata_ff, rx_rdata_ff;
   logic [plf_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                         xfer_ff, xfer_in, rd_ok_ff, rd_ok_in, tx_we;

   logic [plf_pkg::BYTE_W-1:0]   read_byte_ff;
   logic [plf_pkg::STATUS_W-1:0] out_status_ff;
   logic [plf_pkg::COUNT_W-1:0]  rx_count_ff;

   always_comb begin
      slack_inc = (slack_ff == plf_pkg::SLACK_MAX) ? slack_ff : slack_ff + 1'b1;
      tx_wp_in  = tx_wp_ff;
      tx_rp_in  = tx_rp_ff;
      rx_wp_in  = rx_wp_ff;
      rx_rp_in  = rx_rp_ff;
      slack_in  = slack_ff;
      status_in = plf_pkg::ST_OK;
      xfer_in   = 1'b0;
      rd_ok_in  = 1'b0;
      tx_we     = 1'b0;
      case (cmd_ff)
         plf_pkg::CMD_WRITE: begin
            if (plf_pkg::ptr_next(tx_wp_ff) == tx_rp_ff) begin
               status_in = plf_pkg::ST_TX_FULL;
            end else begin
               tx_we    = 1'b1;
               tx_wp_in = plf_pkg::ptr_next(tx_wp_ff);
            end
         end
         plf_pkg::CMD_READ: begin
            if (rx_rp_ff == rx_wp_ff) begin
               status_in = plf_pkg::ST_RX_EMPTY;
            end else begin
               rd_ok_in = 1'b1;
               rx_rp_in = plf_pkg::ptr_next(rx_rp_ff);
            end
         end
         plf_pkg::CMD_TICK: begin
            slack_in = slack_inc;
            if (tx_wp_ff == tx_rp_ff) begin
               status_in = plf_pkg::ST_TX_EMPTY;
            end else if (plf_pkg::ptr_next(rx_wp_ff) == rx_rp_ff) begin
               status_in = plf_pkg::ST_RX_FULL;
            end else if (slack_inc >= plf_pkg::SLACK_W'(period_ff)) begin
               xfer_in  = 1'b1;
               tx_rp_in = plf_pkg::ptr_next(tx_rp_ff);
               rx_wp_in = plf_pkg::ptr_next(rx_wp_ff);
               slack_in = slack_inc - plf_pkg::SLACK_W'(period_ff);
            end else begin
               status_in = plf_pkg::ST_WAIT;
            end
         end
         default: begin
            status_in = plf_pkg::ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_wp_ff  <= '0;
         tx_rp_ff  <= '0;
         rx_wp_ff  <= '0;
         rx_rp_ff  <= '0;
         slack_ff  <= '0;
         period_ff <= '0;
         xfer_ff   <= 1'b0;
         rd_ok_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            period_ff <= csr_wr_data;
         end
         if (cmd.execute) begin
            tx_wp_ff <= tx_wp_in;
            tx_rp_ff <= tx_rp_in;
            rx_wp_ff <= rx_wp_in;
            rx_rp_ff <= rx_rp_in;
            slack_ff <= slack_in;
            xfer_ff  <= xfer_in;
            rd_ok_ff <= rd_ok_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff  <= req_command;
         data_ff <= req_data_byte;
      end
      if (cmd.execute) begin
         status_ff   <= status_in;
         rx_waddr_ff <= rx_wp_ff;
      end
      if (cmd.finish) begin
         read_byte_ff  <= rd_ok_ff ? rx_rdata_ff : '0;
         out_status_ff <= status_ff;
         rx_count_ff   <= plf_pkg::ring_fill(rx_wp_ff, rx_rp_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute && tx_we) begin
         tx_mem[tx_wp_ff] <= data_ff;
      end
      tx_rdata_ff <= tx_mem[tx_rp_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.finish && xfer_ff) begin
         rx_mem[rx_waddr_ff] <= tx_rdata_ff;
      end
      rx_rdata_ff <= rx_mem[rx_rp_ff];
   end

   assign rsp_read_byte = read_byte_ff;
   assign rsp_status    = out_status_ff;
   assign rsp_rx_count  = rx_count_ff;

endmodule

[sv/plf_ctrl.sv]
// Controller of the loopback byte FIFO: sequences capture, execute, finish and
// result hand-off for one beat at a time. Depends on plf_pkg.
module plf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output plf_pkg::plf_cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_FIN  = 4'b0100,
      S_RESP = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_FIN;
         end
         S_FIN: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = (state_ff == S_RESP);
   assign cmd.capture = (state_ff == S_IDLE) && req_valid;
   assign cmd.execute = (state_ff == S_EXEC);
   assign cmd.finish  = (state_ff == S_FIN);

endmodule

[sv/plf_checker.sv]
// Port-level checker of the loopback byte FIFO and its bind to the top level.
// Depends on plf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module plf_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [plf_pkg::BYTE_W-1:0]    rsp_read_byte,
   input logic [plf_pkg::STATUS_W-1:0]  rsp_status,
   input logic [plf_pkg::COUNT_W-1:0]   rsp_rx_count
);

   `PLF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_byte) && $stable(rsp_status) && $stable(rsp_rx_count), "Stalled result beat changed or vanished.")
   `PLF_ASSERT(a_one_in_flight, clock, reset, !(req_ready && rsp_valid), "A command was open while a result beat was waiting.")
   `PLF_ASSERT(a_count_range, clock, reset, !rsp_valid || (rsp_rx_count < plf_pkg::COUNT_W'(plf_pkg::RING_DEPTH)), "Receive count beyond ring capacity.")
   `PLF_ASSERT(a_empty_zero, clock, reset, !rsp_valid || (rsp_status != plf_pkg::ST_RX_EMPTY) || ((rsp_read_byte == '0) && (rsp_rx_count == '0)), "Empty read reported data or a non-zero count.")
   `PLF_ASSERT_NEXT(a_accept_no_rsp, clock, reset, req_valid && req_ready, !rsp_valid && !req_ready, "Result appeared too early after a command beat.")

endmodule

bind paced_loopback_byte_fifo_top plf_checker u_plf_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_read_byte (rsp_bus.read_byte),
   .rsp_status    (rsp_bus.status),
   .rsp_rx_count  (rsp_bus.rx_count)
);
